// ----- hw/rtl/fmed_pkg.sv -----
// shared types and constants for the frame median sorting core
package fmed_pkg;

  localparam int VALUE_W = 32;
  localparam int ICOUNT_W = 8;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_item;
  } sample_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] median_value;
    logic [ICOUNT_W-1:0]       item_count;
    logic                      overflow;
  } result_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_SEEK
  } state_t;

endpackage

// ----- hw/rtl/frame_median_by_sorting_core.sv -----
// top level of the frame median core: insertion sort chain and median readout
//
// usage
//   sample channel: one signed q16.16 value per request, last_item closes the frame
//   result channel: one request per frame with median, kept count and overflow flag
//   every value that fits is inserted into a chain of MAX_ITEMS cells in the
//   cycle it is taken, so within a frame one request is accepted per cycle
//   on the closing request the chain shifts left (n-1)/2 times, n the kept count,
//   one cell per cycle; then the median is taken from the first two cells
//   sample_ready is low after the closing request until the result is loaded;
//   the result shows on the next cycle after that
//   values beyond MAX_ITEMS in one frame are dropped and flagged as overflow
//   the result sits in an output register: a stalled receiver does not block the
//   next frame, only the load of the following result waits for it to drain
//   reset (rst, synchronous) empties the chain count and drops any pending result;
//   cell contents are never cleared, only the count decides which cells hold data
module frame_median_by_sorting_core
  import fmed_pkg::*;
#(
  parameter int MAX_ITEMS = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // control state
  state_t           state, state_next;
  logic [CNT_W-1:0] count;          // values kept in the open frame
  logic             overflowed;     // open frame dropped a value
  logic [CNT_W-1:0] frame_cnt;      // count of the frame being read out
  logic             frame_ovf;
  logic [CNT_W-1:0] remain;         // left shifts still to do

  logic       accept;
  logic       full;
  logic       load;
  logic       seek_done;
  cell_ctrl_t ctrl;

  logic [CNT_W-1:0] count_after;
  logic             ovf_after;

  logic signed [VALUE_W-1:0] cell_val [MAX_ITEMS];
  logic                      cell_gt  [MAX_ITEMS];

  logic signed [VALUE_W:0]   pair_sum;
  logic signed [VALUE_W-1:0] median;

  assign full        = (count == CNT_W'(MAX_ITEMS));
  assign accept      = sample_valid && sample_ready;
  assign count_after = full ? count : count + 1'b1;
  assign ovf_after   = overflowed || full;
  assign seek_done   = (state == ST_SEEK) && (remain == '0);
  assign load        = seek_done && (!result_valid || result_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (accept && sample.last_item) begin
          state_next = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (load) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // state outputs
  always_comb begin
    sample_ready = 1'b0;
    ctrl.ins     = 1'b0;
    ctrl.shl     = 1'b0;
    unique case (state)
      ST_FILL: begin
        sample_ready = 1'b1;
        ctrl.ins     = sample_valid && !full;
      end
      ST_SEEK: begin
        ctrl.shl = (remain != '0);
      end
      default: begin
        sample_ready = 1'b0;
      end
    endcase
  end

  // cell chain: each cell sees its left neighbor for insert, right for shift
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                      occ;
    logic                      lgt;
    logic signed [VALUE_W-1:0] lval;
    logic signed [VALUE_W-1:0] rval;

    assign occ = (IDX < count);

    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lval = sample.sample_value;
    end else begin : g_body
      assign lgt  = cell_gt[i-1];
      assign lval = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rval = cell_val[i];
    end else begin : g_inner
      assign rval = cell_val[i+1];
    end

    fmed_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (sample.sample_value),
      .occupied  (occ),
      .left_gt   (lgt),
      .left_val  (lval),
      .right_val (rval),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  // median from the two head cells; even count takes the floor of the half sum
  assign pair_sum = {cell_val[0][VALUE_W-1], cell_val[0]}
                  + {cell_val[1][VALUE_W-1], cell_val[1]};
  assign median   = frame_cnt[0] ? cell_val[0] : pair_sum[VALUE_W:1];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      count        <= '0;
      overflowed   <= 1'b0;
      remain       <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (sample.last_item) begin
          count      <= '0;
          overflowed <= 1'b0;
          remain     <= (count_after - 1'b1) >> 1;
        end else begin
          count      <= count_after;
          overflowed <= ovf_after;
        end
      end else if (ctrl.shl) begin
        remain <= remain - 1'b1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // frame and result payload
  always_ff @(posedge clk) begin
    if (accept && sample.last_item) begin
      frame_cnt <= count_after;
      frame_ovf <= ovf_after;
    end
    if (load) begin
      result.median_value <= median;
      result.item_count   <= ICOUNT_W'(frame_cnt);
      result.overflow     <= frame_ovf;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("kept count above capacity");

  a_seek_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK && remain != '0) |=>
      (state == ST_SEEK && remain == $past(remain) - 1'b1))
    else $error("readout shift count did not step down");

  a_result_from_seek: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_SEEK && remain == '0))
    else $error("result raised outside readout");

  a_no_insert_in_seek: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEEK) |-> (!sample_ready && !ctrl.ins))
    else $error("insert during readout");

endmodule

// ----- hw/rtl/fmed_cell.sv -----
// one cell of the sorting chain: holds one value, inserts or shifts left
module fmed_cell
  import fmed_pkg::*;
(
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] key,
  input  logic                      occupied,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] left_val,
  input  logic signed [VALUE_W-1:0] right_val,
  output logic signed [VALUE_W-1:0] val,
  output logic                      gt
);

  logic signed [VALUE_W-1:0] val_next;

  // empty cells count as larger than any key; equal keys go after
  assign gt = !occupied || (val > key);

  always_comb begin
    val_next = val;
    if (ctrl.shl) begin
      val_next = right_val;
    end else if (ctrl.ins && gt) begin
      val_next = left_gt ? left_val : key;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
